>>> sv/bba_pkg.sv
// Shared types and constants for the block bitmap allocator.
// No dependencies; imported by every module of the block.
`default_nettype none

package bba_pkg;

   localparam int WORD_BITS  = 8;
   localparam int WORD_SEL_W = 3;
   localparam int BLK_W      = 12;
   localparam int SIZE_W     = 13;
   localparam int WIDX_W     = BLK_W - WORD_SEL_W;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_FIRST = 2'd2,
      REQ_BEST  = 2'd3
   } req_kind_type;

   // search request as held for the length of a scan
   typedef struct packed {
      logic              best;
      logic [SIZE_W-1:0] need;
      logic [BLK_W-1:0]  lo;
      logic [BLK_W-1:0]  hi;
   } scan_cfg_type;

   // per-cycle control from the sequencer to the run tracker
   typedef struct packed {
      logic             clear;
      logic             step;
      logic             last;
      logic [BLK_W-1:0] base;
   } scan_ctl_type;

   // run tracker outputs, valid in the cycle of a step
   typedef struct packed {
      logic             hit;
      logic [BLK_W-1:0] hit_start;
      logic             have;
      logic [BLK_W-1:0] best_start;
   } scan_res_type;

   typedef struct packed {
      logic [SIZE_W-1:0] run;
      logic [BLK_W-1:0]  run_start;
      logic              have;
      logic [SIZE_W-1:0] best_len;
      logic [BLK_W-1:0]  best_start;
   } run_state_type;

endpackage

`default_nettype wire

>>> sv/bba_map_ram.sv
// Allocation map storage: one write port, one read port, registered read.
// Depends on bba_pkg for the word width.
`default_nettype none

module bba_map_ram #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [ADDR_W-1:0]             wr_addr,
   input  wire logic [bba_pkg::WORD_BITS-1:0] wr_data,
   input  wire logic                          rd_en,
   input  wire logic [ADDR_W-1:0]             rd_addr,
   output logic      [bba_pkg::WORD_BITS-1:0] rd_data
);
   import bba_pkg::*;

   logic [WORD_BITS-1:0] map_words [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_words[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= map_words[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> sv/bba_run_tracker.sv
// Free-run tracker: walks the 8 bits of one map word per step and keeps
// the current run, the first-fit hit and the best-fit candidate.
// Depends on bba_pkg.
`default_nettype none

module bba_run_tracker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bba_pkg::scan_cfg_type         cfg,
   input  wire bba_pkg::scan_ctl_type         ctl,
   input  wire logic [bba_pkg::WORD_BITS-1:0] word,
   output bba_pkg::scan_res_type              res
);
   import bba_pkg::*;

   run_state_type st_ff;
   run_state_type st_in;

   function automatic run_state_type close_run(run_state_type s, scan_cfg_type c);
      run_state_type r;
      r = s;
      if (c.best && (s.run >= c.need) && (!s.have || (s.run < s.best_len))) begin
         r.have       = 1'b1;
         r.best_len   = s.run;
         r.best_start = s.run_start;
      end
      r.run = '0;
      return r;
   endfunction

   run_state_type    st;
   logic             hit;
   logic [BLK_W-1:0] hit_start;
   logic [BLK_W-1:0] pos;

   always_comb begin
      st        = st_ff;
      hit       = 1'b0;
      hit_start = '0;
      pos       = '0;
      for (int k = 0; k < WORD_BITS; k++) begin
         pos = ctl.base + BLK_W'(k);
         // skip blocks below the range; past the range counts as used
         if (!hit && (pos >= cfg.lo)) begin
            if ((pos <= cfg.hi) && !word[k]) begin
               if (st.run == '0) begin
                  st.run_start = pos;
               end
               st.run = st.run + 1'b1;
               if (!cfg.best && (st.run == cfg.need)) begin
                  hit       = 1'b1;
                  hit_start = st.run_start;
               end
            end else begin
               st = close_run(st, cfg);
            end
         end
      end
      // a run that reaches the end of the range closes here
      if (ctl.last && !hit) begin
         st = close_run(st, cfg);
      end
   end

   always_comb begin
      if (ctl.clear) begin
         st_in = '0;
      end else if (ctl.step) begin
         st_in = st;
      end else begin
         st_in = st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else begin
         st_ff <= st_in;
      end
   end

   assign res.hit        = ctl.step & hit;
   assign res.hit_start  = hit_start;
   assign res.have       = st.have;
   assign res.best_start = st.best_start;

endmodule

`default_nettype wire

>>> sv/block_bitmap_allocator.sv
// Block bitmap allocator top level: request sequencer, map RAM and run tracker.
// Depends on bba_pkg, bba_map_ram and bba_run_tracker.
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  tuser: kind; tdata: index, mark, size, range
//   rsp_     out  rsp_tvalid/rsp_tready  tdata: found, start block, bit value
//
// Write and read pass through map RAM read, modify and write back, and the result
// register before the next accept; the result word is registered.
// A search walks the range from first word to last word, one map word per cycle
// through the single read port of the map RAM; first fit stops at the hit.
// A search with zero size or an empty range goes to the done state without a map read.
// After reset a clearing pass writes zero to all (NUM_BLOCKS + 7) / 8 map words
// (512 at 4096 blocks), one a cycle, with req_tready low.
// A finished word holds in the done state while the result register is full;
// after that req_tready is high again while that result waits on a stalled rsp_ channel.
`default_nettype none

module block_bitmap_allocator #(
   parameter int NUM_BLOCKS = 4096
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // [1:0] req_type
   input  wire logic [1:0]                     req_tuser,
   // [11:0] block_index, [12] mark_used, [25:13] hole_size,
   // [37:26] range_first, [49:38] range_last, [55:50] zero
   input  wire logic [bba_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [0] found, [12:1] start_block, [13] bit_value, [15:14] zero
   output logic      [bba_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import bba_pkg::*;

   localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_BIT   = 5'b00100,
      S_SCAN  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   function automatic logic block_ok(logic [BLK_W-1:0] b);
      return 32'(b) < 32'(NUM_BLOCKS);
   endfunction

   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   req_kind_type      kind_ff, kind_in;
   logic [BLK_W-1:0]  idx_ff, idx_in;
   logic              mark_ff, mark_in;
   scan_cfg_type      cfg_ff, cfg_in;
   logic [WIDX_W-1:0] hi_w_ff, hi_w_in;
   logic [WIDX_W-1:0] data_w_ff, data_w_in;
   logic [WIDX_W-1:0] next_w_ff, next_w_in;
   logic              res_found_ff, res_found_in;
   logic [BLK_W-1:0]  res_start_ff, res_start_in;
   logic              res_bit_ff, res_bit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [BLK_W-1:0]  rsp_start_ff, rsp_start_in;
   logic              rsp_bit_ff, rsp_bit_in;

   logic                 mem_we;
   logic [AW-1:0]        mem_wa;
   logic [WORD_BITS-1:0] mem_wd;
   logic                 mem_re;
   logic [AW-1:0]        mem_ra;
   logic [WORD_BITS-1:0] mem_rd;

   scan_ctl_type ctl;
   scan_res_type res;

   req_kind_type      in_kind;
   logic [BLK_W-1:0]  in_idx;
   logic              in_mark;
   logic [SIZE_W-1:0] in_need;
   logic [BLK_W-1:0]  in_lo;
   logic [BLK_W-1:0]  in_last;
   logic [BLK_W-1:0]  in_hi;

   assign in_kind = req_kind_type'(req_tuser);
   assign in_idx  = req_tdata[11:0];
   assign in_mark = req_tdata[12];
   assign in_need = req_tdata[25:13];
   assign in_lo   = req_tdata[37:26];
   assign in_last = req_tdata[49:38];
   // clamp the range end to the map
   assign in_hi   = (32'(in_last) >= 32'(NUM_BLOCKS)) ? BLK_W'(NUM_BLOCKS - 1) : in_last;

   logic [WORD_BITS-1:0] wr_word;
   logic                 sel_bit;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      kind_in      = kind_ff;
      idx_in       = idx_ff;
      mark_in      = mark_ff;
      cfg_in       = cfg_ff;
      hi_w_in      = hi_w_ff;
      data_w_in    = data_w_ff;
      next_w_in    = next_w_ff;
      res_found_in = res_found_ff;
      res_start_in = res_start_ff;
      res_bit_in   = res_bit_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_start_in = rsp_start_ff;
      rsp_bit_in   = rsp_bit_ff;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = '0;
      mem_re       = 1'b0;
      mem_ra       = '0;
      ctl          = '0;
      wr_word      = mem_rd;
      sel_bit      = mem_rd[idx_ff[WORD_SEL_W-1:0]] & block_ok(idx_ff);

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in     = in_kind;
               idx_in      = in_idx;
               mark_in     = in_mark;
               cfg_in.best = (in_kind == REQ_BEST);
               cfg_in.need = in_need;
               cfg_in.lo   = in_lo;
               cfg_in.hi   = in_hi;
               res_bit_in  = 1'b0;
               if ((in_kind == REQ_WRITE) || (in_kind == REQ_READ)) begin
                  mem_re   = block_ok(in_idx);
                  mem_ra   = AW'(in_idx[BLK_W-1:WORD_SEL_W]);
                  state_in = S_BIT;
               end else if ((in_need == '0) || (in_lo > in_hi)) begin
                  res_found_in = 1'b0;
                  res_start_in = '0;
                  state_in     = S_DONE;
               end else begin
                  mem_re    = 1'b1;
                  mem_ra    = AW'(in_lo[BLK_W-1:WORD_SEL_W]);
                  data_w_in = in_lo[BLK_W-1:WORD_SEL_W];
                  next_w_in = in_lo[BLK_W-1:WORD_SEL_W] + 1'b1;
                  hi_w_in   = in_hi[BLK_W-1:WORD_SEL_W];
                  ctl.clear = 1'b1;
                  state_in  = S_SCAN;
               end
            end
         end
         S_BIT: begin
            wr_word[idx_ff[WORD_SEL_W-1:0]] = mark_ff;
            if ((kind_ff == REQ_WRITE) && block_ok(idx_ff)) begin
               mem_we = 1'b1;
               mem_wa = AW'(idx_ff[BLK_W-1:WORD_SEL_W]);
               mem_wd = wr_word;
            end
            res_found_in = 1'b0;
            res_start_in = '0;
            res_bit_in   = (kind_ff == REQ_READ) ? sel_bit : 1'b0;
            state_in     = S_DONE;
         end
         S_SCAN: begin
            ctl.step  = 1'b1;
            ctl.last  = (data_w_ff == hi_w_ff);
            ctl.base  = {data_w_ff, {WORD_SEL_W{1'b0}}};
            // prefetch the next word while this one is walked
            mem_re    = ~ctl.last;
            mem_ra    = AW'(next_w_ff);
            data_w_in = next_w_ff;
            next_w_in = next_w_ff + 1'b1;
            if (res.hit) begin
               res_found_in = 1'b1;
               res_start_in = res.hit_start;
               state_in     = S_DONE;
            end else if (ctl.last) begin
               res_found_in = res.have;
               res_start_in = res.have ? res.best_start : '0;
               state_in     = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_start_in = res_start_ff;
               rsp_bit_in   = res_bit_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      idx_ff       <= idx_in;
      mark_ff      <= mark_in;
      cfg_ff       <= cfg_in;
      hi_w_ff      <= hi_w_in;
      data_w_ff    <= data_w_in;
      next_w_ff    <= next_w_in;
      res_found_ff <= res_found_in;
      res_start_ff <= res_start_in;
      res_bit_ff   <= res_bit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
      rsp_bit_ff   <= rsp_bit_in;
   end

   bba_map_ram #(
      .DEPTH  (MAP_WORDS),
      .ADDR_W (AW)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   bba_run_tracker u_run_tracker (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .ctl   (ctl),
      .word  (mem_rd),
      .res   (res)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_bit_ff, rsp_start_ff, rsp_found_ff};

`ifndef NO_ASSERTIONS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_tready)
      else $error("request ready during map clearing pass");

   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == S_CLEAR) || ((state_ff == S_BIT) && (kind_ff == REQ_WRITE))))
      else $error("map write outside clearing pass or bit write");

   a_hit_first_fit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN) && res.hit) |-> !cfg_ff.best)
      else $error("first-fit hit during best-fit search");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (data_w_ff <= hi_w_ff))
      else $error("scan walked past the end of the range");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result word raised outside the done state");
`endif

endmodule

`default_nettype wire
